// ===== hdl/sida_pkg.sv =====
`default_nettype none

package sida_pkg;

    // fixed widths of the conversion
    localparam int VALUE_W       = 32;
    localparam int CHAR_W        = 6;
    localparam int DIGIT_W       = 4;
    localparam int NUM_DIGITS    = 10;
    localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
    localparam int IDX_W         = $clog2(NUM_DIGITS);
    localparam int BITS_PER_STEP = 4;
    localparam int NUM_STEPS     = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(NUM_STEPS);

    // ascii codes, masked to the six-bit character port
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    typedef logic [BCD_W-1:0] bcd_t;

    // classified request: sign and unsigned magnitude
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } item_t;

    // converted request: sign and packed bcd digits
    typedef struct packed {
        logic neg;
        bcd_t bcd;
    } digits_t;

    // one double-dabble step: adjust every digit, then shift one bit in
    function automatic bcd_t dabble_shift(bcd_t bcd, logic in_bit);
        bcd_t adj;
        int   d;
        adj = bcd;
        for (d = 0; d < NUM_DIGITS; d++)
        begin
            if (bcd[d*DIGIT_W +: DIGIT_W] >= 4'd5)
            begin
                adj[d*DIGIT_W +: DIGIT_W] = bcd[d*DIGIT_W +: DIGIT_W] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], in_bit};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sida_front.sv =====
`default_nettype none

module sida_front
    import sida_pkg::*;
(
    input  wire logic signed [VALUE_W-1:0] value,
    output item_t                          item
);

    logic [VALUE_W-1:0] raw;

    // split into sign and magnitude; the most negative value stays exact unsigned
    assign raw      = value;
    assign item.neg = raw[VALUE_W-1];
    assign item.mag = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;

endmodule

`default_nettype wire

// ===== hdl/sida_fifo.sv =====
`default_nettype none

module sida_fifo
    import sida_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output item_t      pop_item,
    output logic       empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sida_conv.sv =====
`default_nettype none

module sida_conv
    import sida_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_empty,
    input  wire item_t q_item,
    output logic       q_pop,
    output logic       res_valid,
    output digits_t    res_data,
    input  wire logic  res_take
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic               neg_reg;
    logic [VALUE_W-1:0] shift_reg;
    bcd_t               bcd_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [VALUE_W-1:0] shift_next;
    bcd_t               bcd_next;

    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign res_valid = (state_reg == ST_DONE);
    assign res_data  = '{neg: neg_reg, bcd: bcd_reg};

    // four binary bits into the bcd accumulator per cycle
    always_comb
    begin
        bcd_t               t;
        logic [VALUE_W-1:0] s;
        int                 k;
        t = bcd_reg;
        s = shift_reg;
        for (k = 0; k < BITS_PER_STEP; k++)
        begin
            t = dabble_shift(t, s[VALUE_W-1]);
            s = {s[VALUE_W-2:0], 1'b0};
        end
        bcd_next   = t;
        shift_next = s;
    end

    // sequencer and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            neg_reg   <= 1'b0;
            shift_reg <= '0;
            bcd_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        neg_reg   <= q_item.neg;
                        shift_reg <= q_item.mag;
                        bcd_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    bcd_reg   <= bcd_next;
                    shift_reg <= shift_next;
                    step_reg  <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(NUM_STEPS - 1))
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (res_take)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sida_emit.sv =====
`default_nettype none

module sida_emit
    import sida_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire digits_t           in_data,
    output logic                   in_take,
    output logic                   empty,
    input  wire logic              pop,
    output logic [CHAR_W-1:0]      character,
    output logic                   last
);

    logic               busy_reg;
    logic               sign_reg;
    logic [IDX_W-1:0]   idx_reg;
    bcd_t               bcd_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;
    logic [IDX_W-1:0]   top_idx;
    logic [DIGIT_W-1:0] cur_digit;
    logic               advance;

    assign in_take   = !busy_reg;
    assign empty     = !out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;
    assign advance   = busy_reg && (!out_valid_reg || pop);
    assign cur_digit = bcd_reg[idx_reg*DIGIT_W +: DIGIT_W];

    // highest non-zero digit, or the units digit for zero
    always_comb
    begin
        int d;
        top_idx = '0;
        for (d = 1; d < NUM_DIGITS; d++)
        begin
            if (in_data.bcd[d*DIGIT_W +: DIGIT_W] != '0)
            begin
                top_idx = IDX_W'(d);
            end
        end
    end

    // character walk and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            sign_reg      <= 1'b0;
            idx_reg       <= '0;
            bcd_reg       <= '0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (!busy_reg && in_valid)
            begin
                busy_reg <= 1'b1;
                sign_reg <= in_data.neg;
                idx_reg  <= top_idx;
                bcd_reg  <= in_data.bcd;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                if (sign_reg)
                begin
                    char_reg <= CHAR_MINUS;
                    last_reg <= 1'b0;
                    sign_reg <= 1'b0;
                end
                else
                begin
                    char_reg <= CHAR_ZERO + CHAR_W'(cur_digit);
                    last_reg <= (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        busy_reg <= 1'b0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg - 1'b1;
                    end
                end
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// Converts each 32-bit two's-complement request into its decimal ASCII text, one
// character per result, most significant digit first, with a leading minus for
// negative values and no leading zeros; zero gives "0" and the most negative
// value gives "-2147483648". The final character of each text has last set.
// Character codes are the low six bits of ASCII (45 for minus, 48 to 57 for
// digits). A front stage splits sign and magnitude into a short request queue
// (QUEUE_DEPTH entries); the back converts the magnitude to BCD four bits per
// cycle and hands it to a character stage that walks the digits into a
// registered output. Conversion of one request overlaps the output of the one
// before.
`default_nettype none

module signed_int_to_decimal_ascii
    import sida_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic signed [VALUE_W-1:0] value,
    output logic                           empty,
    input  wire logic                      pop,
    output logic [CHAR_W-1:0]              character,
    output logic                           last
);

    item_t   front_item;
    item_t   q_item;
    logic    q_empty;
    logic    q_pop;
    logic    conv_valid;
    digits_t conv_data;
    logic    conv_take;

    // sign and magnitude split
    sida_front u_front
    (
        .value (value),
        .item  (front_item)
    );

    // request queue between front and back
    sida_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .empty     (q_empty)
    );

    // binary to bcd
    sida_conv u_conv
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (conv_valid),
        .res_data  (conv_data),
        .res_take  (conv_take)
    );

    // digit walk and output register
    sida_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (conv_valid),
        .in_data   (conv_data),
        .in_take   (conv_take),
        .empty     (empty),
        .pop       (pop),
        .character (character),
        .last      (last)
    );

endmodule

`default_nettype wire

// ===== hdl/sida_chk.sv =====
`default_nettype none

module sida_chk
    import sida_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      empty,
    input  wire logic                      pop,
    input  wire logic [CHAR_W-1:0]         character,
    input  wire logic                      last
);

    logic mid_run_reg;
    logic after_minus_reg;
    logic taken;

    assign taken = pop && !empty;

    // position within the current text, from taken characters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_run_reg     <= 1'b0;
            after_minus_reg <= 1'b0;
        end
        else if (taken)
        begin
            mid_run_reg     <= !last;
            after_minus_reg <= (character == CHAR_MINUS) && !last;
        end
    end

    // a waiting character holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(character) && $stable(last)))
        else $error("waiting character changed before it was taken");

    // only minus or a digit is shown
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (character == CHAR_MINUS
                    || (character >= CHAR_ZERO && character <= CHAR_ZERO + 6'd9)))
        else $error("character outside minus and digits");

    // minus only opens a text and never ends it
    a_minus: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && character == CHAR_MINUS) |-> (!mid_run_reg && !last))
        else $error("minus sign out of place");

    // no leading zero unless the text is exactly zero
    a_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && character == CHAR_ZERO && !mid_run_reg) |-> last)
        else $error("leading zero in text");

    // a minus is followed by a non-zero digit
    a_after_minus: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && after_minus_reg) |-> (character != CHAR_ZERO && character != CHAR_MINUS))
        else $error("minus not followed by a non-zero digit");

endmodule

bind signed_int_to_decimal_ascii sida_chk u_sida_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .character (character),
    .last      (last)
);

`default_nettype wire

// ===== tb/sv/tb_signed_int_to_decimal_ascii.sv =====
module tb_signed_int_to_decimal_ascii
    import sida_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_VALUES = 300;
    localparam int CHUNK         = 50;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 40;

    // one character of the expected decimal text
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } text_char_t;

    // keeps the decimal text still owed for every accepted request
    class decimal_text_scoreboard;
        text_char_t expected_text[$];
        int         failures;

        function new();
            failures = 0;
        endfunction

        // work out the text of an accepted value, most significant digit first
        function void note_value(logic signed [VALUE_W-1:0] v);
            logic [VALUE_W-1:0] mag;
            logic [DIGIT_W-1:0] digit_stack[$];
            logic               neg;
            text_char_t         entry;
            neg = v[VALUE_W-1];
            mag = v;
            if (neg)
            begin
                mag = -mag;
            end
            do
            begin
                digit_stack.push_front(DIGIT_W'(mag % 10));
                mag = mag / 10;
            end
            while (mag != 0);
            if (neg)
            begin
                entry.character = CHAR_MINUS;
                entry.last      = 1'b0;
                expected_text.push_back(entry);
            end
            foreach (digit_stack[i])
            begin
                entry.character = CHAR_ZERO + CHAR_W'(digit_stack[i]);
                entry.last      = (i == digit_stack.size() - 1);
                expected_text.push_back(entry);
            end
        endfunction

        // compare one accepted character with the oldest one owed
        function void check_char(logic [CHAR_W-1:0] c, logic l);
            text_char_t owed;
            if (expected_text.size() == 0)
            begin
                $error("character %0d arrived with nothing outstanding", c);
                failures++;
                return;
            end
            owed = expected_text.pop_front();
            if (c !== owed.character)
            begin
                $error("character: expected %0d, actual %0d", owed.character, c);
                failures++;
            end
            if (l !== owed.last)
            begin
                $error("last: expected %0b, actual %0b", owed.last, l);
                failures++;
            end
        endfunction

        function int pending();
            return expected_text.size();
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      push  = 1'b0;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      pop   = 1'b0;
    logic                      full;
    logic                      empty;
    logic [CHAR_W-1:0]         character;
    logic                      last;

    decimal_text_scoreboard board;
    int in_idle_pct  = 25;
    int out_idle_pct = 25;
    int idle_cycles  = 0;

    signed_int_to_decimal_ascii dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .value     (value),
        .empty     (empty),
        .pop       (pop),
        .character (character),
        .last      (last)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // present one value, after an optional gap, and hold it until taken
    task automatic send_value(input logic signed [VALUE_W-1:0] v);
        int gap;
        gap = ($urandom_range(0, 99) < in_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push  <= 1'b1;
        value <= v;
        do @(posedge clk); while (full);
        board.note_value(v);
    endtask

    // result side: check every popped character, stall in short bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (pop && !empty)
                begin
                    board.check_char(character, last);
                end
                if (stall_left > 0)
                begin
                    stall_left--;
                    pop <= 1'b0;
                end
                else if ($urandom_range(0, 99) < out_idle_pct)
                begin
                    stall_left = $urandom_range(0, 3);
                    pop <= 1'b0;
                end
                else
                begin
                    pop <= 1'b1;
                end
            end
        end
    end

    // watchdog on cycles in which neither a request nor a character moves
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        logic signed [VALUE_W-1:0] directed[$];
        logic signed [VALUE_W-1:0] v;
        int unsigned               lo;
        int unsigned               hi;
        int                        ndig;
        int                        n;
        directed = '{
            32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
            32'sd99, 32'sd100, -32'sd100, 32'sd999999999, -32'sd999999999,
            32'sd1000000000, 32'sd2147483647, -32'sd2147483647,
            32'sh8000_0000, 32'sh5555_5555, 32'shAAAA_AAAA
        };
        board = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // edges of the range, some digit count boundaries and both signs
        foreach (directed[i])
        begin
            send_value(directed[i]);
        end

        // random values: mostly chosen by digit count, some raw words
        for (n = 0; n < RANDOM_VALUES; n++)
        begin
            if (n % CHUNK == 0)
            begin
                if (n >= RANDOM_VALUES - CHUNK)
                begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
                else
                begin
                    in_idle_pct  = $urandom_range(0, 2) * 30;
                    out_idle_pct = $urandom_range(0, 2) * 30;
                end
            end
            if ($urandom_range(0, 3) == 0)
            begin
                v = $urandom;
            end
            else
            begin
                ndig = $urandom_range(1, 10);
                lo = 1;
                repeat (ndig - 1) lo = lo * 10;
                hi = (ndig == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
                if (ndig == 1)
                begin
                    lo = 0;
                end
                v = $urandom_range(hi, lo);
                if ($urandom_range(0, 1) == 1)
                begin
                    v = -v;
                end
            end
            send_value(v);
        end
        push <= 1'b0;

        // drain, then give the block time to show any stray character
        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.failures == 0 && board.pending() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
